[hw/rtl/aes_ctr_pkg.sv]
// Package for the AES counter-mode keystream cipher.
// Holds the S-box, round helpers, register indexes and state types.
// Depends on nothing.
package aes_ctr_pkg;

  localparam int KeySlots   = 15;
  localparam int SlotBits   = 4;
  localparam int BlockBytes = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 64;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ROUND_COUNT = 2'd0,
    REG_NONCE_HIGH  = 2'd1,
    REG_NONCE_LOW   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOAD  = 2'd1,
    ST_ROUND = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic       load;
    logic       first;
    logic       last;
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits in bits 127-8i .. 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c) -: 8]     = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

[hw/rtl/aes_ctr_if.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on nothing.
interface aes_ctr_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  key_slot;
  logic [63:0] word_high;
  logic [63:0] word_low;
  logic [4:0]  byte_count;
  logic        restart;
  modport source (output valid, cmd, key_slot, word_high, word_low, byte_count, restart,
                  input ready);
  modport sink (input valid, cmd, key_slot, word_high, word_low, byte_count, restart,
                output ready);
endinterface

interface aes_ctr_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] text_high;
  logic [63:0] text_low;
  modport source (output valid, text_high, text_low, input ready);
  modport sink (input valid, text_high, text_low, output ready);
endinterface

[hw/rtl/aes_ctr_keystream_cipher_top.sv]
// AES counter-mode cipher top level: sequencer, key table, counter, output register.
// Depends on aes_ctr_pkg, aes_ctr_if and aes_ctr_round.
//
// Use: write round_count, nonce_high and nonce_low on the configuration port
// while idle. Send key items (cmd 0) to fill round key slots 0..round_count,
// then data items (cmd 1). Each data item with a nonzero byte_count gives one
// result item: the data XORed with the encrypted counter block, bytes at and
// beyond byte_count zeroed. restart reloads the counter from nonce_low first.
// Key items can be accepted back to back, each written to its slot as it is
// accepted. A data item goes from its accepting edge through the initial key XOR
// after the table read, one round per cycle in the shared round unit, then the
// output load onto the output register. The next item is accepted in the cycle
// after the result is loaded, so data items pass one at a time through the
// single round unit, which takes a new one only when the last is through.
// The block accepts nothing while a data item is in work. A stalled receiver
// holds the result in the output register; a following result then waits in the
// sequencer's final step until the register is free.
// Reset clears the counter and nonce and sets the round count to 10; key slots
// are undefined until written.
module aes_ctr_keystream_cipher_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [aes_ctr_pkg::CfgDataBits-1:0] cfg_data,
  aes_ctr_in_if.sink                          in_ch,
  aes_ctr_out_if.source                       out_ch
);
  logic [127:0] key_mem [aes_ctr_pkg::KeySlots];
  logic [127:0] round_key;
  logic [3:0]   round_count;
  logic [63:0]  nonce_high;
  logic [63:0]  nonce_low;
  logic [31:0]  block_counter;
  logic [31:0]  counter_use;
  aes_ctr_pkg::state_t state, state_next;
  logic [3:0]   round;
  logic [3:0]   round_next;
  logic [3:0]   nr;
  logic [3:0]   rd_addr;
  logic [127:0] data;
  logic [4:0]   count;
  logic [127:0] ks;
  logic [127:0] masked;
  logic         out_valid;
  logic [127:0] out_data;
  aes_ctr_pkg::round_ctrl_t ctrl;
  logic         accept;
  logic         data_go;
  logic         done_fire;

  assign in_ch.ready = (state == aes_ctr_pkg::ST_IDLE);
  assign accept  = in_ch.valid && in_ch.ready;
  assign data_go = accept && in_ch.cmd && (in_ch.byte_count != 5'd0);
  assign counter_use = in_ch.restart ? nonce_low[31:0] : block_counter;
  assign done_fire = (state == aes_ctr_pkg::ST_DONE) && (!out_valid || out_ch.ready);

  always_comb begin
    if (round_count == 4'd0) begin
      nr = 4'd1;
    end else if (round_count == 4'd15) begin
      nr = 4'd14;
    end else begin
      nr = round_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= 4'd10;
      nonce_high  <= '0;
      nonce_low   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_ctr_pkg::REG_ROUND_COUNT: round_count <= cfg_data[3:0];
        aes_ctr_pkg::REG_NONCE_HIGH:  nonce_high  <= cfg_data;
        aes_ctr_pkg::REG_NONCE_LOW:   nonce_low   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_ch.cmd && (in_ch.key_slot < 4'(aes_ctr_pkg::KeySlots))) begin
      key_mem[in_ch.key_slot] <= {in_ch.word_high, in_ch.word_low};
    end
    round_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (accept && in_ch.cmd) begin
      if (data_go) begin
        block_counter <= counter_use + 32'd1;
      end else if (in_ch.restart) begin
        block_counter <= nonce_low[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_go) begin
      data  <= {in_ch.word_high, in_ch.word_low};
      count <= (in_ch.byte_count > 5'd16) ? 5'd16 : in_ch.byte_count;
      ks    <= {nonce_high, nonce_low[63:32], counter_use};
    end
  end

  always_comb begin
    state_next = state;
    round_next = round;
    rd_addr    = round;
    ctrl       = '0;
    unique case (state)
      aes_ctr_pkg::ST_IDLE: begin
        rd_addr = 4'd0;
        if (data_go) begin
          state_next = aes_ctr_pkg::ST_LOAD;
          round_next = 4'd1;
        end
      end
      aes_ctr_pkg::ST_LOAD: begin
        ctrl.load  = 1'b1;
        rd_addr    = round;
        state_next = aes_ctr_pkg::ST_ROUND;
        round_next = round + 4'd1;
      end
      aes_ctr_pkg::ST_ROUND: begin
        ctrl.first = (round - 4'd1) != nr;
        ctrl.last  = (round - 4'd1) == nr;
        rd_addr    = ctrl.last ? 4'd0 : round;
        round_next = round + 4'd1;
        if (ctrl.last) begin
          state_next = aes_ctr_pkg::ST_DONE;
        end
      end
      aes_ctr_pkg::ST_DONE: begin
        if (done_fire) begin
          state_next = aes_ctr_pkg::ST_IDLE;
        end
      end
      default: state_next = aes_ctr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_ctr_pkg::ST_IDLE;
      round <= '0;
    end else begin
      state <= state_next;
      round <= round_next;
    end
  end

  logic [127:0] cipher;
  aes_ctr_round u_round (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (ks),
    .round_key  (round_key),
    .state      (cipher)
  );

  always_comb begin
    for (int i = 0; i < aes_ctr_pkg::BlockBytes; i++) begin
      masked[127 - 8*i -: 8] = (5'(i) < count) ?
        (cipher[127 - 8*i -: 8] ^ data[127 - 8*i -: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data <= masked;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.text_high = out_data[127:64];
  assign out_ch.text_low  = out_data[63:0];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != aes_ctr_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_done_from_round: assert property (@(posedge clk) disable iff (rst)
    (state == aes_ctr_pkg::ST_ROUND && ctrl.last) |=> state == aes_ctr_pkg::ST_DONE)
    else $error("last round not followed by done");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(out_data))
    else $error("result lost");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == aes_ctr_pkg::ST_ROUND) |-> round <= nr + 4'd1) else $error("round overrun");
`endif
endmodule

[hw/rtl/aes_ctr_round.sv]
// Shared AES round unit: one round per enabled cycle on a 128-bit state register.
// Depends on aes_ctr_pkg.
module aes_ctr_round (
  input  logic                     clk,
  input  aes_ctr_pkg::round_ctrl_t ctrl,
  input  logic [127:0]             load_value,
  input  logic [127:0]             round_key,
  output logic [127:0]             state
);
  logic [127:0] sub;
  logic [127:0] state_next;

  always_comb begin
    sub = aes_ctr_pkg::sub_shift(state);
    if (ctrl.load) begin
      state_next = load_value ^ round_key;
    end else if (ctrl.last) begin
      state_next = sub ^ round_key;
    end else begin
      state_next = aes_ctr_pkg::mix_columns(sub) ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.first || ctrl.last) begin
      state <= state_next;
    end
  end
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the AES counter-mode keystream cipher top level.
// Depends on aes_ctr_pkg (S-box, register indexes) and the aes_ctr_if channel interfaces.
// Predicts every result with its own AES round sequence and compares field by field.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic        cmd;
    logic [3:0]  key_slot;
    logic [63:0] word_high;
    logic [63:0] word_low;
    logic [4:0]  byte_count;
    logic        restart;
  } cipher_item_t;

  typedef struct {
    cipher_item_t it;
    bit           silent;
  } stim_row_t;

  typedef struct {
    logic [63:0] text_high;
    logic [63:0] text_low;
  } text_t;

  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [aes_ctr_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [aes_ctr_pkg::CfgDataBits-1:0] cfg_data = '0;

  aes_ctr_in_if in_ch (clk);
  aes_ctr_out_if out_ch (clk);

  aes_ctr_keystream_cipher_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [127:0] key_model [aes_ctr_pkg::KeySlots];
  logic [31:0]  ctr_value;
  logic [3:0]   rounds_cfg;
  logic [63:0]  nonce_hi_cfg;
  logic [63:0]  nonce_lo_cfg;
  text_t        pending_text [$];
  int           errors;
  int           cycles;
  int           texts_checked;
  int           key_writes;
  int           items_sent;
  int           stall_left;
  bit           steady;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] byte_sub_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] =
          aes_ctr_pkg::SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] b [4];
    logic [7:0] sum;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) b[r] = s[127 - 8*(4*c + r) -: 8];
      sum = b[0] ^ b[1] ^ b[2] ^ b[3];
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = b[r] ^ sum ^ gf_double(b[r] ^ b[(r + 1) % 4]);
    end
    return t;
  endfunction

  function automatic logic [127:0] keystream_block();
    int nr;
    logic [127:0] s;
    nr = int'(rounds_cfg);
    if (nr < 1) nr = 1;
    if (nr > aes_ctr_pkg::KeySlots - 1) nr = aes_ctr_pkg::KeySlots - 1;
    s = {nonce_hi_cfg, nonce_lo_cfg[63:32], ctr_value} ^ key_model[0];
    for (int r = 1; r < nr; r++) s = column_mix(byte_sub_rows(s)) ^ key_model[r];
    return byte_sub_rows(s) ^ key_model[nr];
  endfunction

  // Updates the predicted state for one accepted item; returns 1 when a result follows.
  function automatic bit cipher_predict(input cipher_item_t it, output text_t res);
    logic [127:0] blk;
    int n;
    res = '{default: '0};
    if (it.cmd == 1'b0) begin
      if (it.key_slot < aes_ctr_pkg::KeySlots)
        key_model[it.key_slot] = {it.word_high, it.word_low};
      return 0;
    end
    if (it.restart) ctr_value = nonce_lo_cfg[31:0];
    n = int'(it.byte_count);
    if (n == 0) return 0;
    if (n > aes_ctr_pkg::BlockBytes) n = aes_ctr_pkg::BlockBytes;
    blk = keystream_block() ^ {it.word_high, it.word_low};
    for (int i = n; i < aes_ctr_pkg::BlockBytes; i++) blk[127 - 8*i -: 8] = 8'h00;
    res.text_high = blk[127:64];
    res.text_low = blk[63:0];
    ctr_value = ctr_value + 32'd1;
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drive_item(input cipher_item_t it, input bit silent);
    text_t res;
    bit has;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.key_slot <= it.key_slot;
    in_ch.word_high <= it.word_high;
    in_ch.word_low <= it.word_low;
    in_ch.byte_count <= it.byte_count;
    in_ch.restart <= it.restart;
    do @(posedge clk); while (!in_ch.ready);
    has = cipher_predict(it, res);
    if (silent && has) begin
      $error("item expected to give no result: cmd=%0d byte_count=%0d", it.cmd, it.byte_count);
      errors++;
    end
    if (has) pending_text.push_back(res);
    if (it.cmd == 1'b0) key_writes++;
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_settings(input logic [3:0] rc, input logic [63:0] nh,
                                input logic [63:0] nl);
    in_ch.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= aes_ctr_pkg::REG_ROUND_COUNT;
    cfg_data <= {60'd0, rc};
    @(posedge clk);
    cfg_index <= aes_ctr_pkg::REG_NONCE_HIGH;
    cfg_data <= nh;
    @(posedge clk);
    cfg_index <= aes_ctr_pkg::REG_NONCE_LOW;
    cfg_data <= nl;
    @(posedge clk);
    cfg_we <= 1'b0;
    rounds_cfg = rc;
    nonce_hi_cfg = nh;
    nonce_lo_cfg = nl;
  endtask

  function automatic cipher_item_t random_item();
    cipher_item_t it;
    int r;
    it.cmd = ($urandom_range(0, 99) >= 8);
    it.key_slot = 4'($urandom_range(0, 15));
    it.word_high = rand64();
    it.word_low = rand64();
    it.restart = ($urandom_range(0, 99) < 10);
    r = $urandom_range(0, 99);
    if (r < 65) it.byte_count = 5'd16;
    else if (r < 87) it.byte_count = 5'($urandom_range(1, 15));
    else if (r < 93) it.byte_count = 5'd0;
    else it.byte_count = 5'($urandom_range(17, 31));
    return it;
  endfunction

  always @(posedge clk) begin
    text_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_text.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pending_text.pop_front();
        texts_checked++;
        if (out_ch.text_high !== want.text_high) begin
          $error("text_high expected %h actual %h", want.text_high, out_ch.text_high);
          errors++;
        end
        if (out_ch.text_low !== want.text_low) begin
          $error("text_low expected %h actual %h", want.text_low, out_ch.text_low);
          errors++;
        end
      end
    end
    if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 30)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    logic [3:0] rc_list [9];
    cipher_item_t it;

    errors = 0;
    cycles = 0;
    texts_checked = 0;
    key_writes = 0;
    items_sent = 0;
    stall_left = 0;
    steady = 1'b0;
    ctr_value = '0;
    rounds_cfg = 4'd10;
    nonce_hi_cfg = '0;
    nonce_lo_cfg = '0;
    foreach (key_model[i]) key_model[i] = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.key_slot = '0;
    in_ch.word_high = '0;
    in_ch.word_low = '0;
    in_ch.byte_count = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill every key slot, then exercise the byte count and restart corners.
    for (int s = 0; s < aes_ctr_pkg::KeySlots; s++) begin
      row.it = '{1'b0, 4'(s), rand64(), rand64(), 5'd0, 1'b0};
      if (s == 0) row.it.word_high = '1;
      if (s == 0) row.it.word_low = '1;
      if (s == 1) row.it.word_high = '0;
      if (s == 1) row.it.word_low = '0;
      row.silent = 1'b1;
      rows.push_back(row);
    end
    rows.push_back('{'{1'b0, 4'd15, '1, '1, 5'd31, 1'b1}, 1'b1});
    rows.push_back('{'{1'b1, 4'd0, '1, '1, 5'd16, 1'b1}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, '0, '0, 5'd16, 1'b0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, '1, '1, 5'd1, 1'b0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, '1, '1, 5'd0, 1'b1}, 1'b1});
    rows.push_back('{'{1'b1, 4'd0, '1, '0, 5'd15, 1'b0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, '0, '1, 5'd17, 1'b0}, 1'b0});
    rows.push_back('{'{1'b1, 4'd0, '1, '1, 5'd31, 1'b0}, 1'b0});

    write_settings(4'd10, '1, 64'hffff_ffff_ffff_fffe);
    foreach (rows[i]) drive_item(rows[i].it, rows[i].silent);

    // Settings cover counts 1 and 10 to 14, the clamped 0 and 15, and a counter wrap.
    rc_list = '{4'd12, 4'd14, 4'd0, 4'd1, 4'd11, 4'd13, 4'd15, 4'd10, 4'd14};
    foreach (rc_list[p]) begin
      write_settings(rc_list[p], (p == 0) ? 64'd0 : rand64(),
                     (p % 3 == 0) ? {$urandom, 32'hffff_fff0} : rand64());
      steady = (p == 4);
      for (int k = 0; k < 64; k++) begin
        it = random_item();
        if (k == 0) it.restart = 1'b1;
        drive_item(it, 1'b0);
      end
      steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d items (%0d key writes), checked %0d result items", items_sent,
             key_writes, texts_checked);
    $display("round counts 0, 1 and 10 to 15, partial and oversized blocks, counter wrap");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
